// File: rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the toroidal life engine
// Sizes of the cell grid, item and result formats, controller commands.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Grid storage limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_AW     = $clog2(MAX_WIDTH);
    localparam int ROW_AW     = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 7;
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(3);

    // Item operation codes
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [1:0] FUNC_ADVANCE = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Input item
    typedef struct packed {
        logic [1:0] func;
        logic [5:0] x;
        logic [5:0] y;
        logic       value;
    } lgs_req_t;

    // Result item
    typedef struct packed {
        logic cell_value;
        logic index_error;
    } lgs_rsp_t;

    // Column memory read address source
    typedef enum logic [2:0] {
        RD_ITEM = 3'd0,
        RD_LAST = 3'd1,
        RD_ZERO = 3'd2,
        RD_ONE  = 3'd3,
        RD_NEXT = 3'd4
    } lgs_rd_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        lgs_rd_t rd_sel;
        logic    cell_fin;
        logic    clear_all;
        logic    load_left;
        logic    load_first;
        logic    gen_step;
        logic    respond;
    } lgs_ctl_t;

endpackage

// File: rtl/life_generation_step_torus.sv
// ----------------------------------------------------------------------------
// life_generation_step_torus: toroidal life grid with cell access and stepping
//
//   channel   | signals                                   | handshake
//   ----------+-------------------------------------------+----------------------
//   item in   | start, busy, request                      | start & !busy
//   result    | done, response                            | one-cycle strobe
//   config    | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// Write and read pass through S_CELL, clear answers from idle, and advance
// steps through S_G0, S_G1 and S_G2, then rewrites one column word per cycle
// through the column memory. The result strobe follows the final cycle of the
// item; the next item may start in that same cycle. Reset clears the control
// state and marks all columns dead; sizes return to 64. Results cannot be stalled.
// ----------------------------------------------------------------------------
module life_generation_step_torus (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lgs_pkg::lgs_req_t request,
    output logic              done,
    output lgs_pkg::lgs_rsp_t response,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW = lgs_pkg::SIZE_W;

    logic [SW-1:0] width_reg;
    logic [SW-1:0] height_reg;
    logic          cfg_wr;
    logic [SW-1:0] cfg_w_clamped;
    logic [SW-1:0] cfg_h_clamped;
    logic          last_col;
    lgs_pkg::lgs_ctl_t ctl;

    // Saturate a size into its legal range
    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] maxv);
        logic [SW-1:0] r;
        begin
            r = v;
            if (v < lgs_pkg::SIZE_MIN)
            begin
                r = lgs_pkg::SIZE_MIN;
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign cfg_w_clamped = clamp_size(pwdata[SW-1:0], SW'(lgs_pkg::MAX_WIDTH));
    assign cfg_h_clamped = clamp_size(pwdata[SW-1:0], SW'(lgs_pkg::MAX_HEIGHT));

    // Hold grid size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(lgs_pkg::MAX_WIDTH);
            height_reg <= SW'(lgs_pkg::MAX_HEIGHT);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == lgs_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_w_clamped;
            end
            else
            begin
                height_reg <= cfg_h_clamped;
            end
        end
    end

    // Register readback
    assign prdata = (paddr[2] == lgs_pkg::REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (request.func),
        .last_col (last_col),
        .busy     (busy),
        .ctl      (ctl)
    );

    lgs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .grid_width  (width_reg),
        .grid_height (height_reg),
        .ctl         (ctl),
        .last_col    (last_col),
        .done        (done),
        .response    (response)
    );

    // A result only appears while the block is free for the next item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A cell access answers once its S_CELL step is through
    a_cell_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.func == lgs_pkg::FUNC_WRITE ||
                            request.func == lgs_pkg::FUNC_READ))
        |-> ##1 !done ##1 done)
        else $error("cell access result not on time");

    // A clear answers in the next cycle with no error and no cell value
    a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func == lgs_pkg::FUNC_CLEAR)
        |=> done && !response.cell_value && !response.index_error)
        else $error("clear result wrong");

    // A generation sweep keeps the block busy after it is taken
    a_adv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func == lgs_pkg::FUNC_ADVANCE)
        |=> busy && !done)
        else $error("advance did not start a sweep");

endmodule

// File: rtl/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl: sequencer for cell access, clear and generation sweep
// Steps the datapath through each item and flags when the result is due.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       func,
    input  logic             last_col,
    output logic             busy,
    output lgs_pkg::lgs_ctl_t ctl
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CELL = 6'b000010,
        S_G0   = 6'b000100,
        S_G1   = 6'b001000,
        S_G2   = 6'b010000,
        S_GRUN = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands for the current step
    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.rd_sel     = lgs_pkg::RD_ITEM;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_item = 1'b1;
                    case (func)
                        lgs_pkg::FUNC_WRITE, lgs_pkg::FUNC_READ:
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = lgs_pkg::RD_ITEM;
                            state_next = S_CELL;
                        end
                        lgs_pkg::FUNC_CLEAR:
                        begin
                            ctl.clear_all = 1'b1;
                            ctl.respond   = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_G0;
                        end
                    endcase
                end
            end
            S_CELL:
            begin
                ctl.cell_fin = 1'b1;
                ctl.respond  = 1'b1;
                state_next   = S_IDLE;
            end
            // fetch the old last column, it is the left neighbor of column 0
            S_G0:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = lgs_pkg::RD_LAST;
                state_next = S_G1;
            end
            S_G1:
            begin
                ctl.load_left = 1'b1;
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = lgs_pkg::RD_ZERO;
                state_next    = S_G2;
            end
            S_G2:
            begin
                ctl.load_first = 1'b1;
                ctl.rd_en      = 1'b1;
                ctl.rd_sel     = lgs_pkg::RD_ONE;
                state_next     = S_GRUN;
            end
            // one column per cycle until the last column in use
            S_GRUN:
            begin
                ctl.gen_step = 1'b1;
                ctl.rd_en    = 1'b1;
                ctl.rd_sel   = lgs_pkg::RD_NEXT;
                if (last_col)
                begin
                    ctl.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/lgs_dpath.sv
// ----------------------------------------------------------------------------
// lgs_dpath: column memory, neighbor evaluation and result registers
// Holds the grid as one word per column; a sweep rewrites one column a cycle.
// ----------------------------------------------------------------------------
module lgs_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lgs_pkg::lgs_req_t             request,
    input  logic [lgs_pkg::SIZE_W-1:0]    grid_width,
    input  logic [lgs_pkg::SIZE_W-1:0]    grid_height,
    input  lgs_pkg::lgs_ctl_t             ctl,
    output logic                          last_col,
    output logic                          done,
    output lgs_pkg::lgs_rsp_t             response
);

    localparam int H  = lgs_pkg::MAX_HEIGHT;
    localparam int W  = lgs_pkg::MAX_WIDTH;
    localparam int CA = lgs_pkg::COL_AW;
    localparam int RA = lgs_pkg::ROW_AW;

    // Column memory and per-column valid bits (invalid reads as all dead)
    logic [H-1:0] col_mem [W];
    logic [W-1:0] valid_reg;

    logic [H-1:0]  rd_data_reg;
    logic [CA-1:0] rd_addr;
    logic          wr_en;
    logic [CA-1:0] wr_addr;
    logic [H-1:0]  wr_data;

    // Captured item
    logic [CA-1:0] x_reg;
    logic [RA-1:0] y_reg;
    logic          value_reg;
    logic          is_write_reg;

    // Sweep state
    logic [H-1:0]  left_reg;
    logic [H-1:0]  cur_reg;
    logic [H-1:0]  save0_reg;
    logic [CA-1:0] cx_reg;

    logic [CA-1:0] w_last;
    logic [RA-1:0] h_last;
    logic          err;
    logic [H-1:0]  right_col;
    logic [H-1:0]  new_col;
    logic [H-1:0]  cell_word;

    logic          done_reg;
    lgs_pkg::lgs_rsp_t rsp_reg;
    lgs_pkg::lgs_rsp_t rsp_next;

    // Neighbor above each row, wrapping at the last row in use
    function automatic logic [H-1:0] col_up(input logic [H-1:0] c, input logic [RA-1:0] hl);
        logic [H-1:0] r;
        begin
            r = {c[H-2:0], c[hl]};
            return r;
        end
    endfunction

    // Neighbor below each row, wrapping at the last row in use
    function automatic logic [H-1:0] col_dn(input logic [H-1:0] c, input logic [RA-1:0] hl);
        logic [H-1:0] r;
        begin
            r     = {c[0], c[H-1:1]};
            r[hl] = c[0];
            return r;
        end
    endfunction

    assign w_last   = CA'(grid_width - lgs_pkg::SIZE_W'(1));
    assign h_last   = RA'(grid_height - lgs_pkg::SIZE_W'(1));
    assign last_col = (cx_reg == w_last);
    assign err      = ({1'b0, x_reg} >= grid_width) || ({1'b0, y_reg} >= grid_height);

    // Select read address
    always_comb
    begin
        case (ctl.rd_sel)
            lgs_pkg::RD_ITEM: rd_addr = request.x;
            lgs_pkg::RD_LAST: rd_addr = w_last;
            lgs_pkg::RD_ZERO: rd_addr = '0;
            lgs_pkg::RD_ONE:  rd_addr = CA'(1);
            lgs_pkg::RD_NEXT: rd_addr = cx_reg + CA'(2);
            default:          rd_addr = '0;
        endcase
    end

    // Evaluate the life rule on the current column, rows above the region hold
    assign right_col = last_col ? save0_reg : rd_data_reg;

    always_comb
    begin
        logic [H-1:0] lu, ld, cu, cd, ru, rd;
        logic [3:0]   n;
        lu = col_up(left_reg, h_last);
        ld = col_dn(left_reg, h_last);
        cu = col_up(cur_reg, h_last);
        cd = col_dn(cur_reg, h_last);
        ru = col_up(right_col, h_last);
        rd = col_dn(right_col, h_last);
        n  = '0;
        for (int i = 0; i < H; i++)
        begin
            n = 4'(lu[i]) + 4'(left_reg[i]) + 4'(ld[i]) + 4'(cu[i]) + 4'(cd[i])
              + 4'(ru[i]) + 4'(right_col[i]) + 4'(rd[i]);
            if (RA'(i) > h_last)
            begin
                new_col[i] = cur_reg[i];
            end
            else
            begin
                new_col[i] = (n == 4'd3) || (cur_reg[i] && (n == 4'd2));
            end
        end
    end

    // Replace the addressed bit for a cell write
    always_comb
    begin
        cell_word        = rd_data_reg;
        cell_word[y_reg] = value_reg;
    end

    // Write port: cell write or sweep column
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = x_reg;
        wr_data = cell_word;
        if (ctl.cell_fin && is_write_reg && !err)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.gen_step)
        begin
            wr_en   = 1'b1;
            wr_addr = cx_reg;
            wr_data = new_col;
        end
    end

    // Memory array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? col_mem[rd_addr] : '0;
        end
    end

    // Valid bits: clear drops all columns, any write marks its column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Capture item and advance sweep registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            x_reg        <= request.x;
            y_reg        <= request.y;
            value_reg    <= request.value;
            is_write_reg <= (request.func == lgs_pkg::FUNC_WRITE);
        end
        if (ctl.load_left)
        begin
            left_reg <= rd_data_reg;
        end
        if (ctl.load_first)
        begin
            cur_reg   <= rd_data_reg;
            save0_reg <= rd_data_reg;
            cx_reg    <= '0;
        end
        else if (ctl.gen_step)
        begin
            left_reg <= cur_reg;
            cur_reg  <= right_col;
            cx_reg   <= cx_reg + CA'(1);
        end
    end

    // Result for the finishing item
    always_comb
    begin
        rsp_next = '0;
        if (ctl.cell_fin)
        begin
            rsp_next.index_error = err;
            rsp_next.cell_value  = !is_write_reg && !err && rd_data_reg[y_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.respond)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

// File: test/life_generation_step_torus_test.sv
// ----------------------------------------------------------------------------
// life_generation_step_torus_test: self-checking bench for the toroidal life grid
// Drives cell writes, reads, clears and generation steps under several grid
// sizes and sender idle patterns. It predicts each response from its own copy
// of the grid and checks every response strobe in order.
// ----------------------------------------------------------------------------
module life_generation_step_torus_test;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam int unsigned PHASE_COUNT    = 12;
    localparam int unsigned PHASE_ITEMS    = 100;

    // Grid model, expected responses and mismatch bookkeeping
    class life_scoreboard;
        logic [lgs_pkg::MAX_HEIGHT-1:0] columns [lgs_pkg::MAX_WIDTH];
        int unsigned                    width_used;
        int unsigned                    height_used;
        lgs_pkg::lgs_rsp_t              pending_responses [$];
        int unsigned                    mismatches;

        function new();
            foreach (columns[i])
                columns[i] = '0;
            width_used  = lgs_pkg::MAX_WIDTH;
            height_used = lgs_pkg::MAX_HEIGHT;
            mismatches  = 0;
        endfunction

        function int unsigned clamp_size(logic [lgs_pkg::SIZE_W-1:0] raw,
                                         int unsigned maxv);
            if (raw < 3)
                return 3;
            if (raw > maxv)
                return maxv;
            return raw;
        endfunction

        function void set_size(logic reg_idx, logic [31:0] data);
            if (reg_idx == lgs_pkg::REG_WIDTH)
                width_used = clamp_size(data[lgs_pkg::SIZE_W-1:0], lgs_pkg::MAX_WIDTH);
            else
                height_used = clamp_size(data[lgs_pkg::SIZE_W-1:0], lgs_pkg::MAX_HEIGHT);
        endfunction

        // Advance the region in use one generation; rows and columns outside keep
        function void step_generation();
            logic [lgs_pkg::MAX_HEIGHT-1:0] col_zero, col_west, col_east, cur, nxt;
            int unsigned cx, cy, up, dn, n;
            col_zero = columns[0];
            col_west = columns[width_used-1];
            for (cx = 0; cx < width_used; cx++)
            begin
                cur      = columns[cx];
                col_east = (cx + 1 == width_used) ? col_zero : columns[cx+1];
                nxt      = cur;
                for (cy = 0; cy < height_used; cy++)
                begin
                    up = (cy == 0) ? height_used - 1 : cy - 1;
                    dn = (cy + 1 == height_used) ? 0 : cy + 1;
                    n  = col_west[up] + col_west[cy] + col_west[dn]
                       + cur[up] + cur[dn]
                       + col_east[up] + col_east[cy] + col_east[dn];
                    nxt[cy] = (n == 3) || (cur[cy] && n == 2);
                end
                columns[cx] = nxt;
                col_west    = cur;
            end
        endfunction

        // Apply one accepted item and queue the response it must produce
        function void note_item(lgs_pkg::lgs_req_t item);
            lgs_pkg::lgs_rsp_t rsp;
            rsp = '0;
            case (item.func)
                lgs_pkg::FUNC_WRITE, lgs_pkg::FUNC_READ:
                begin
                    if (item.x >= width_used || item.y >= height_used)
                        rsp.index_error = 1'b1;
                    else if (item.func == lgs_pkg::FUNC_WRITE)
                        columns[item.x][item.y] = item.value;
                    else
                        rsp.cell_value = columns[item.x][item.y];
                end
                lgs_pkg::FUNC_CLEAR:
                begin
                    foreach (columns[i])
                        columns[i] = '0;
                end
                default:
                    step_generation();
            endcase
            pending_responses.push_back(rsp);
        endfunction

        function void check_response(lgs_pkg::lgs_rsp_t got);
            lgs_pkg::lgs_rsp_t want;
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: cell_value=%0b index_error=%0b",
                             got.cell_value, got.index_error);
                return;
            end
            want = pending_responses.pop_front();
            if (got.cell_value !== want.cell_value)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cell_value mismatch: expected %0b, got %0b",
                             want.cell_value, got.cell_value);
            end
            if (got.index_error !== want.index_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("index_error mismatch: expected %0b, got %0b",
                             want.index_error, got.index_error);
            end
        endfunction

        function int unsigned outstanding();
            return pending_responses.size();
        endfunction

        function bit clean();
            return mismatches == 0 && pending_responses.size() == 0;
        endfunction
    endclass

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    lgs_pkg::lgs_req_t request = '0;
    logic              done;
    lgs_pkg::lgs_rsp_t response;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    life_scoreboard sb;
    int unsigned    idle_pct = 0;
    int unsigned    quiet_cycles = 0;

    life_generation_step_torus uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Check every response strobe against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_response(response);
    end

    // Abort when no item, response or register write moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic lgs_pkg::lgs_req_t make_item(logic [1:0] func, int unsigned x,
                                                    int unsigned y, bit value);
        lgs_pkg::lgs_req_t item;
        item.func  = func;
        item.x     = x[5:0];
        item.y     = y[5:0];
        item.value = value;
        return item;
    endfunction

    // Hold the item on the port until accepted, with an optional idle gap first
    task automatic send_item(input lgs_pkg::lgs_req_t item);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(item);
    endtask

    // Drop start and wait for every response and for the block to go idle
    task automatic settle();
        start <= 1'b0;
        while (sb.outstanding() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic reg_idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_size(reg_idx, data);
    endtask

    task automatic send_in_range(input logic [1:0] func, input bit value);
        send_item(make_item(func, $urandom_range(0, sb.width_used - 1),
                            $urandom_range(0, sb.height_used - 1), value));
    endtask

    task automatic send_noise();
        send_item(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                            $urandom_range(0, 63), 1'($urandom_range(0, 1))));
    endtask

    // Seed a pattern, step it a few generations, and sample cells after each
    task automatic run_phase(input int unsigned quota);
        int unsigned sent, cells, nwrites, ngens, nreads, g, r;
        sent  = 0;
        cells = sb.width_used * sb.height_used;
        while (sent < quota)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(make_item(lgs_pkg::FUNC_CLEAR, $urandom_range(0, 63),
                                    $urandom_range(0, 63), 1'($urandom_range(0, 1))));
                sent++;
            end
            nwrites = $urandom_range(3, (cells < 24) ? cells : 24);
            repeat (nwrites)
            begin
                send_in_range(lgs_pkg::FUNC_WRITE, $urandom_range(0, 99) < 55);
                sent++;
            end
            ngens = $urandom_range(1, 3);
            for (g = 0; g < ngens; g++)
            begin
                send_item(make_item(lgs_pkg::FUNC_ADVANCE, $urandom_range(0, 63),
                                    $urandom_range(0, 63), 1'($urandom_range(0, 1))));
                sent++;
                nreads = $urandom_range(2, (cells < 10) ? cells : 10);
                for (r = 0; r < nreads; r++)
                begin
                    send_in_range(lgs_pkg::FUNC_READ, 1'($urandom_range(0, 1)));
                    sent++;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_noise();
                        sent++;
                    end
                end
            end
        end
    endtask

    initial
    begin
        logic [31:0] phase_w [PHASE_COUNT];
        logic [31:0] phase_h [PHASE_COUNT];
        int unsigned p;
        phase_w = '{32'd3, 32'd4, 32'd64, 32'd3, 32'd0, 32'd127,
                    32'd6, 32'd8, 32'd64, 32'd5, 32'hFFFF_FF87, 32'd3};
        phase_h = '{32'd3, 32'd5, 32'd3, 32'd64, 32'd127, 32'd2,
                    32'd6, 32'd5, 32'd64, 32'd8, 32'h8000_0107, 32'd4};
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blinker across the corner at the reset size: wraps in both axes
        send_item(make_item(lgs_pkg::FUNC_WRITE, 63, 0, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_WRITE, 0, 0, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_WRITE, 1, 0, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 0, 0, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_ADVANCE, 0, 0, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_READ, 0, 63, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 0, 1, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_READ, 63, 0, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 0, 0, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_WRITE, 63, 63, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 63, 63, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_WRITE, 63, 63, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_CLEAR, 63, 63, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 0, 0, 1'b0));

        // Smallest grid: out-of-range indexes and a lone cell dying
        settle();
        reg_write(lgs_pkg::REG_WIDTH, 32'd3);
        reg_write(lgs_pkg::REG_HEIGHT, 32'd3);
        send_item(make_item(lgs_pkg::FUNC_WRITE, 2, 2, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_WRITE, 3, 0, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_WRITE, 0, 3, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 63, 63, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_READ, 2, 2, 1'b0));
        send_item(make_item(lgs_pkg::FUNC_ADVANCE, 63, 63, 1'b1));
        send_item(make_item(lgs_pkg::FUNC_READ, 2, 2, 1'b1));

        // Random phases over a range of sizes and sender idle patterns
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            reg_write(lgs_pkg::REG_WIDTH, phase_w[p]);
            reg_write(lgs_pkg::REG_HEIGHT, phase_h[p]);
            case (p % 4)
                1: idle_pct = 66;
                3: idle_pct = 18;
                default: idle_pct = 0;
            endcase
            run_phase(PHASE_ITEMS);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.clean())
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
